FILE: src/mesh_vertex_normal_encode_defines.svh
// Assertion macros shared by the vertex encoder RTL.
`ifndef MESH_VERTEX_NORMAL_ENCODE_DEFINES_SVH
`define MESH_VERTEX_NORMAL_ENCODE_DEFINES_SVH
`ifndef SYNTHESIS
`define MVNE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MVNE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MVNE_ASSERT_SAME(lbl, ante, cons)
`define MVNE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: src/mvne_pkg.sv
// Shared constants, types and tables of the vertex encoder.
`timescale 1ns / 1ps
package mvne_pkg;

    localparam int POS_FRAC_BITS_DEF = 16;
    localparam int CORDIC_STEPS_DEF  = 16;

    localparam int SQRT_STEPS = 15;
    localparam int ROOT_W     = 30;
    localparam int CW         = 28;
    localparam int AW         = 26;
    localparam int ATAN_LEN   = 24;
    localparam int ANGLE_BITS = 24;
    localparam int PRESCALE_SHIFT = 8;

    localparam logic signed [AW-1:0] QUARTER_TURN = AW'(4194304);
    localparam logic [7:0] POLE_SOUTH_CODE = 8'h80;

    localparam logic signed [AW-1:0] ATAN_TBL [ATAN_LEN] = '{
        26'sd2097152, 26'sd1238021, 26'sd654136, 26'sd332050,
        26'sd166669, 26'sd83416, 26'sd41718, 26'sd20860,
        26'sd10430, 26'sd5215, 26'sd2608, 26'sd1304,
        26'sd652, 26'sd326, 26'sd163, 26'sd81,
        26'sd41, 26'sd20, 26'sd10, 26'sd5,
        26'sd3, 26'sd1, 26'sd1, 26'sd0
    };

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [AW-1:0] ang;
    } cordic_vec_t;

    typedef struct packed {
        logic [ROOT_W-1:0] n;
        logic [ROOT_W-1:0] res;
    } root_t;

    function automatic logic signed [AW-1:0] atan_step(input int i);
        if (i < ATAN_LEN)
        begin
            return ATAN_TBL[i];
        end
        return '0;
    endfunction

endpackage

FILE: src/mesh_vertex_normal_encode.sv
// Top level of the mesh vertex encoder: position packing and normal angle coding.
// Throughput: one vertex per cycle; the whole pipeline advances together and holds
// only while the output register is full and not taken.
// Depth is set by the 15-stage square root followed by the CORDIC rotation stages.
// Reset (rst_n, asynchronous, active low) clears every valid bit; data is not reset.
`timescale 1ns / 1ps
`include "mesh_vertex_normal_encode_defines.svh"
module mesh_vertex_normal_encode #(
    parameter int POS_FRAC_BITS = mvne_pkg::POS_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS  = mvne_pkg::CORDIC_STEPS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x[31:0], pos_y[63:32], pos_z[95:64], normal_x[111:96],
    // normal_y[127:112], normal_z[143:128]
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // packed_x[15:0], packed_y[31:16], packed_z[47:32], normal_code[63:48]
    output logic [63:0]  m_tdata
);

    localparam int POS_SHIFT = POS_FRAC_BITS - 6;
    localparam logic [32:0] POS_MASK = (33'(1) << POS_SHIFT) - 33'(1);
    localparam int SIDE_D = mvne_pkg::SQRT_STEPS + 1 + CORDIC_STEPS;
    localparam int LAT = 2 + mvne_pkg::SQRT_STEPS + 1 + CORDIC_STEPS + 1;
    localparam int PRW = mvne_pkg::AW + 9;
    localparam logic [PRW-1:0] ANG_MASK = (PRW'(1) << mvne_pkg::ANGLE_BITS) - PRW'(1);

    typedef struct packed {
        logic [15:0] px;
        logic [15:0] py;
        logic [15:0] pz;
        logic        pole;
        logic        zpos;
    } side_t;

    typedef struct packed {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] zc;
    } norm_t;

    logic               en;
    logic [LAT-1:0]     vld_reg;
    logic [143:0]       in_reg;
    side_t              side_b_reg;
    norm_t              norm_b_reg;
    logic [mvne_pkg::ROOT_W-1:0] n_b_reg;
    side_t              side_reg [SIDE_D];
    norm_t              norm_reg [mvne_pkg::SQRT_STEPS];
    logic [63:0]        out_reg;

    logic signed [15:0] nz_raw;
    logic signed [15:0] zc_b;
    logic signed [31:0] zsq_b;
    logic [mvne_pkg::SQRT_STEPS-1:0] root;
    logic signed [15:0] pol_y;
    logic signed [mvne_pkg::AW-1:0] az_ang;
    logic signed [mvne_pkg::AW-1:0] pol_ang;
    side_t              side_o;
    logic [15:0]        code_o;

    // Scale by 64 (a shift by the fraction bits less six), truncate toward zero and
    // saturate to 16 bits.
    function automatic logic [15:0] pack_pos(input logic signed [31:0] p);
        logic signed [32:0] biased;
        logic signed [32:0] v;
        biased = 33'(p) + (p[31] ? $signed(POS_MASK) : 33'sd0);
        v = biased >>> POS_SHIFT;
        if (v < -33'sd32768)
        begin
            return 16'h8000;
        end
        if (v > 33'sd32767)
        begin
            return 16'h7fff;
        end
        return v[15:0];
    endfunction

    // Angle to byte: a * 255 / 2^24, truncated toward zero, low eight bits kept.
    function automatic logic [7:0] angle_byte(input logic signed [mvne_pkg::AW-1:0] a);
        logic signed [PRW-1:0] pr;
        logic signed [PRW-1:0] q;
        pr = (PRW'(a) <<< 8) - PRW'(a);
        q = (pr + (pr[PRW-1] ? $signed(ANG_MASK) : PRW'(0))) >>> mvne_pkg::ANGLE_BITS;
        return q[7:0];
    endfunction

    // The whole pipeline moves as one; it stalls only when the output beat waits.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // Stage A: input register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_reg <= s_tdata;
        end
    end

    // Stage B: position packing, z clamp and the radicand 2^28 - z^2.
    always_comb
    begin
        nz_raw = in_reg[143:128];
        if (nz_raw > 16'sd16384)
        begin
            zc_b = 16'sd16384;
        end
        else if (nz_raw < -16'sd16384)
        begin
            zc_b = -16'sd16384;
        end
        else
        begin
            zc_b = nz_raw;
        end
        zsq_b = zc_b * zc_b;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_b_reg.px   <= pack_pos(in_reg[31:0]);
            side_b_reg.py   <= pack_pos(in_reg[63:32]);
            side_b_reg.pz   <= pack_pos(in_reg[95:64]);
            side_b_reg.pole <= (in_reg[111:96] == '0) && (in_reg[127:112] == '0);
            side_b_reg.zpos <= !nz_raw[15] && (nz_raw != '0);
            norm_b_reg      <= '{nx: in_reg[111:96], ny: in_reg[127:112], zc: zc_b};
            n_b_reg         <= mvne_pkg::ROOT_W'(32'sd268435456 - zsq_b);
        end
    end

    mvne_sqrt_pipe u_sqrt (
        .clk  (clk),
        .en   (en),
        .n_in (n_b_reg),
        .root (root)
    );

    // Normal components wait for the square root; packed positions and pole flags
    // wait for the angles.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            norm_reg[0] <= norm_b_reg;
            for (int i = 1; i < mvne_pkg::SQRT_STEPS; i++)
            begin
                norm_reg[i] <= norm_reg[i-1];
            end
            side_reg[0] <= side_b_reg;
            for (int i = 1; i < SIDE_D; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign pol_y = $signed({1'b0, root});

    mvne_cordic_pipe #(.STEPS(CORDIC_STEPS)) u_cordic_az (
        .clk     (clk),
        .en      (en),
        .in_x    (norm_reg[mvne_pkg::SQRT_STEPS-1].nx),
        .in_y    (norm_reg[mvne_pkg::SQRT_STEPS-1].ny),
        .ang_out (az_ang)
    );

    mvne_cordic_pipe #(.STEPS(CORDIC_STEPS)) u_cordic_pol (
        .clk     (clk),
        .en      (en),
        .in_x    (norm_reg[mvne_pkg::SQRT_STEPS-1].zc),
        .in_y    (pol_y),
        .ang_out (pol_ang)
    );

    // Output stage: a normal on the pole gets a fixed code from the sign of z.
    always_comb
    begin
        side_o = side_reg[SIDE_D-1];
        if (side_o.pole)
        begin
            code_o = side_o.zpos ? 16'h0000 : {8'h00, mvne_pkg::POLE_SOUTH_CODE};
        end
        else
        begin
            code_o = {angle_byte(az_ang), angle_byte(pol_ang)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= {code_o, side_o.pz, side_o.py, side_o.px};
        end
    end

    `MVNE_ASSERT_NEXT(a_stall_freezes_valids, !en, $stable(vld_reg))
    `MVNE_ASSERT_NEXT(a_pole_code, en && side_o.pole,
        (m_tdata[63:48] == 16'h0000) || (m_tdata[63:48] == 16'h0080))
    `MVNE_ASSERT_NEXT(a_bubble_enters, en && !s_tvalid, !vld_reg[0])

endmodule

FILE: src/mvne_sqrt_pipe.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module mvne_sqrt_pipe (
    input  logic                           clk,
    input  logic                           en,
    input  logic [mvne_pkg::ROOT_W-1:0]    n_in,
    output logic [mvne_pkg::SQRT_STEPS-1:0] root
);

    mvne_pkg::root_t st_reg [mvne_pkg::SQRT_STEPS];

    function automatic mvne_pkg::root_t root_step(input mvne_pkg::root_t s,
                                                  input logic [mvne_pkg::ROOT_W-1:0] bv);
        mvne_pkg::root_t r;
        logic [mvne_pkg::ROOT_W-1:0] trial;
        trial = s.res + bv;
        if (s.n >= trial)
        begin
            r.n   = s.n - trial;
            r.res = (s.res >> 1) + bv;
        end
        else
        begin
            r.n   = s.n;
            r.res = s.res >> 1;
        end
        return r;
    endfunction

    for (genvar k = 0; k < mvne_pkg::SQRT_STEPS; k++)
    begin : g_step
        localparam logic [mvne_pkg::ROOT_W-1:0] BITV =
            mvne_pkg::ROOT_W'(1) << (2 * (mvne_pkg::SQRT_STEPS - 1 - k));
        mvne_pkg::root_t src;
        if (k == 0)
        begin : g_first
            assign src = '{n: n_in, res: '0};
        end
        else
        begin : g_rest
            assign src = st_reg[k-1];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[k] <= root_step(src, BITV);
            end
        end
    end

    assign root = st_reg[mvne_pkg::SQRT_STEPS-1].res[mvne_pkg::SQRT_STEPS-1:0];

endmodule

FILE: src/mvne_cordic_pipe.sv
// Vectoring CORDIC atan2, one micro-rotation per pipeline stage.
`timescale 1ns / 1ps
module mvne_cordic_pipe #(
    parameter int STEPS = mvne_pkg::CORDIC_STEPS_DEF
) (
    input  logic                             clk,
    input  logic                             en,
    input  logic signed [15:0]               in_x,
    input  logic signed [15:0]               in_y,
    output logic signed [mvne_pkg::AW-1:0]   ang_out
);

    mvne_pkg::cordic_vec_t st_reg [STEPS+1];
    mvne_pkg::cordic_vec_t prep;
    logic signed [mvne_pkg::CW-1:0] xs;
    logic signed [mvne_pkg::CW-1:0] ys;

    // Scale by 256, then fold the left half-plane onto the right one.
    always_comb
    begin
        xs = mvne_pkg::CW'(in_x) <<< mvne_pkg::PRESCALE_SHIFT;
        ys = mvne_pkg::CW'(in_y) <<< mvne_pkg::PRESCALE_SHIFT;
        prep = '{x: xs, y: ys, ang: '0};
        if (xs < 0)
        begin
            if (ys >= 0)
            begin
                prep = '{x: ys, y: -xs, ang: mvne_pkg::QUARTER_TURN};
            end
            else
            begin
                prep = '{x: -ys, y: xs, ang: -mvne_pkg::QUARTER_TURN};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= prep;
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_rot
        localparam logic signed [mvne_pkg::AW-1:0] STEP_ANG = mvne_pkg::atan_step(i);
        mvne_pkg::cordic_vec_t cur;
        mvne_pkg::cordic_vec_t nxt;
        assign cur = st_reg[i];
        always_comb
        begin
            if (cur.y < 0)
            begin
                nxt.x   = cur.x - (cur.y >>> i);
                nxt.y   = cur.y + (cur.x >>> i);
                nxt.ang = cur.ang - STEP_ANG;
            end
            else
            begin
                nxt.x   = cur.x + (cur.y >>> i);
                nxt.y   = cur.y - (cur.x >>> i);
                nxt.ang = cur.ang + STEP_ANG;
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[i+1] <= nxt;
            end
        end
    end

    assign ang_out = st_reg[STEPS].ang;

endmodule

FILE: bench/mesh_vertex_normal_encode_checker.sv
// Checker for the vertex encoder: predicts each output beat and compares it field by field.
`timescale 1ns / 1ps
module mesh_vertex_normal_encode_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [143:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [63:0]  m_tdata,
    output int           fail_count,
    output int           pending
);

    localparam int FRAC_BITS = mvne_pkg::POS_FRAC_BITS_DEF;
    localparam int STEPS     = mvne_pkg::CORDIC_STEPS_DEF;

    logic [63:0] encoded_q[$];

    const longint ARC_UNITS[24] = '{
        2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
        10430, 5215, 2608, 1304, 652, 326, 163, 81,
        41, 20, 10, 5, 3, 1, 1, 0
    };

    function automatic logic [15:0] scale_coord(input logic signed [31:0] raw);
        longint p;
        longint v;
        p = raw;
        // Truncation toward zero: shift the magnitude.
        v = (p < 0) ? -((-p) >>> (FRAC_BITS - 6)) : (p >>> (FRAC_BITS - 6));
        if (v < -32768)
        begin
            v = -32768;
        end
        if (v > 32767)
        begin
            v = 32767;
        end
        return v[15:0];
    endfunction

    function automatic longint vector_angle(input longint yin, input longint xin);
        longint x;
        longint y;
        longint ang;
        longint t;
        longint dx;
        longint dy;
        x = xin * 256;
        y = yin * 256;
        ang = 0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t; ang = 4194304;
            end
            else
            begin
                t = x; x = -y; y = t; ang = -4194304;
            end
        end
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y < 0)
            begin
                x -= dx; y += dy; ang -= (i < 24) ? ARC_UNITS[i] : 0;
            end
            else
            begin
                x += dx; y -= dy; ang += (i < 24) ? ARC_UNITS[i] : 0;
            end
        end
        return ang;
    endfunction

    function automatic logic [7:0] angle_to_byte(input longint a);
        longint p;
        longint b;
        p = a * 255;
        b = (p < 0) ? -((-p) >>> 24) : (p >>> 24);
        return b[7:0];
    endfunction

    function automatic logic [15:0] normal_latlong(input logic signed [15:0] nx,
                                                   input logic signed [15:0] ny,
                                                   input logic signed [15:0] nz);
        longint zc;
        longint rem;
        longint root;
        if (nx == 0 && ny == 0)
        begin
            return (nz > 0) ? 16'h0000 : 16'h0080;
        end
        zc = nz;
        if (zc > 16384)
        begin
            zc = 16384;
        end
        if (zc < -16384)
        begin
            zc = -16384;
        end
        rem = 268435456 - zc * zc;
        // Integer square root by search on the bounded range.
        root = 0;
        for (int b = 14; b >= 0; b--)
        begin
            if ((root + (64'd1 << b)) * (root + (64'd1 << b)) <= rem)
            begin
                root += (64'd1 << b);
            end
        end
        return {angle_to_byte(vector_angle(ny, nx)), angle_to_byte(vector_angle(root, zc))};
    endfunction

    task automatic report_mismatch(input string field, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t: %s got %h expected %h", $realtime, field, got, want);
        fail_count++;
    endtask

    assign pending = encoded_q.size();

    initial
    begin
        fail_count = 0;
    end

    always @(posedge clk)
    begin
        logic [63:0] want;
        if (rst_n && s_tvalid && s_tready)
        begin
            encoded_q.push_back({normal_latlong(s_tdata[111:96], s_tdata[127:112],
                                                s_tdata[143:128]),
                                 scale_coord(s_tdata[95:64]), scale_coord(s_tdata[63:32]),
                                 scale_coord(s_tdata[31:0])});
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (encoded_q.size() == 0)
            begin
                $display("%0t: output beat with nothing expected", $realtime);
                fail_count++;
            end
            else
            begin
                want = encoded_q.pop_front();
                if (m_tdata[15:0] !== want[15:0])
                begin
                    report_mismatch("packed_x", m_tdata[15:0], want[15:0]);
                end
                if (m_tdata[31:16] !== want[31:16])
                begin
                    report_mismatch("packed_y", m_tdata[31:16], want[31:16]);
                end
                if (m_tdata[47:32] !== want[47:32])
                begin
                    report_mismatch("packed_z", m_tdata[47:32], want[47:32]);
                end
                if (m_tdata[63:48] !== want[63:48])
                begin
                    report_mismatch("normal_code", m_tdata[63:48], want[63:48]);
                end
            end
        end
    end

endmodule

FILE: bench/tb_mesh_vertex_normal_encode.sv
// Testbench top for the vertex encoder: stimulus, back-pressure phases and verdict.
`timescale 1ns / 1ps
module tb_mesh_vertex_normal_encode;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z from the lowest bit up
    logic [143:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // packed_x, packed_y, packed_z, normal_code from the lowest bit up
    logic [63:0]  m_tdata;
    int           fail_count;
    int           pending;
    int           send_idle_pct;
    int           sink_stall_pct;
    bit           hold_sink;
    longint       cycle_count;

    mesh_vertex_normal_encode i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    mesh_vertex_normal_encode_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // The receiver stalls at random; during a hold-off it stays low throughout.
    always @(posedge clk)
    begin
        m_tready <= !hold_sink && ($urandom_range(99) >= sink_stall_pct);
    end

    // Watchdog: the slowest correct run is far below this.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("mesh_vertex_normal_encode: mismatch");
            $finish;
        end
    end

    // Random normal: mostly near the unit range, with wide values and pole cases mixed in.
    function automatic logic [15:0] pick_normal();
        case ($urandom_range(9))
            0:       return 16'($urandom);
            1:       return 16'h0000;
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(4))
            0:       return $urandom;
            default: return 32'($signed($urandom_range(4194304)) - 2097152);
        endcase
    endfunction

    // Offers one beat and holds it until the block takes it.
    task automatic send_vertex(input logic [31:0] px, input logic [31:0] py,
                               input logic [31:0] pz, input logic [15:0] nx,
                               input logic [15:0] ny, input logic [15:0] nz);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {nz, ny, nx, pz, py, px};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic random_vertices(input int count);
        for (int k = 0; k < count; k++)
        begin
            send_vertex(pick_coord(), pick_coord(), pick_coord(),
                        pick_normal(), pick_normal(), pick_normal());
        end
    endtask

    initial
    begin
        int drain;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        hold_sink = 1'b0;
        cycle_count = 0;
        send_idle_pct = 0;
        sink_stall_pct = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats: coordinate extremes, saturation, poles, clamped and skewed normals.
        send_vertex(32'h7fffffff, 32'h80000000, 32'h00000000, 16'sd16384, 16'sd0, 16'sd0);
        send_vertex(32'h001fffff, 32'hffe00000, 32'hffe00001, 16'sd0, 16'sd0, 16'sd16384);
        send_vertex(32'h00200000, 32'hffdfffff, 32'h000003ff, 16'sd0, 16'sd0, -16'sd16384);
        send_vertex(32'hfffffc01, 32'h00000400, 32'hfffffc00, 16'sd0, 16'sd0, 16'sd0);
        send_vertex(32'hffffffff, 32'h00000001, 32'h00010000, 16'sd0, 16'sd0, 16'sh8000);
        send_vertex(32'h0, 32'h0, 32'h0, 16'sd0, 16'sd0, 16'sh7fff);
        send_vertex(32'h0, 32'h0, 32'h0, -16'sd16384, 16'sd0, 16'sd0);
        send_vertex(32'h0, 32'h0, 32'h0, 16'sd0, 16'sd16384, 16'sd0);
        send_vertex(32'h0, 32'h0, 32'h0, 16'sd0, -16'sd16384, 16'sd0);
        send_vertex(32'h0, 32'h0, 32'h0, -16'sd11585, -16'sd11585, 16'sd0);
        send_vertex(32'h0, 32'h0, 32'h0, -16'sd11585, 16'sd11585, 16'sd0);
        send_vertex(32'h0, 32'h0, 32'h0, 16'sh7fff, 16'sh8000, 16'sh7fff);
        send_vertex(32'h0, 32'h0, 32'h0, 16'sh8000, 16'sh7fff, 16'sh8000);
        send_vertex(32'h0, 32'h0, 32'h0, 16'sd1, 16'sd0, 16'sd16383);
        send_vertex(32'h0, 32'h0, 32'h0, 16'sd0, -16'sd1, -16'sd16383);
        send_vertex(32'h0, 32'h0, 32'h0, -16'sd1, 16'sd0, 16'sd20000);
        send_vertex(32'h0, 32'h0, 32'h0, 16'shffff, 16'shffff, 16'shffff);

        random_vertices(350);
        send_idle_pct = 50;
        random_vertices(300);
        send_idle_pct = 0;
        sink_stall_pct = 50;
        random_vertices(300);
        send_idle_pct = 16;
        sink_stall_pct = 16;
        random_vertices(250);

        // Long hold-off on the output while the sender keeps offering beats.
        send_idle_pct = 0;
        sink_stall_pct = 0;
        fork
            begin
                hold_sink = 1'b1;
                repeat (200) @(posedge clk);
                hold_sink = 1'b0;
            end
            random_vertices(300);
        join
        s_tvalid <= 1'b0;

        drain = 0;
        while (pending != 0 && drain < 20000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (60) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("mesh_vertex_normal_encode: match");
        end
        else
        begin
            $display("mesh_vertex_normal_encode: mismatch");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/mvne_pkg.sv
src/mvne_sqrt_pipe.sv
src/mvne_cordic_pipe.sv
src/mesh_vertex_normal_encode.sv
bench/mesh_vertex_normal_encode_checker.sv
bench/tb_mesh_vertex_normal_encode.sv
